[rtl/core/periodic_timer_16bit_regs_top_assert.svh]
// assertion macros for the periodic timer top level
`ifndef PERIODIC_TIMER_16BIT_REGS_TOP_ASSERT_SVH
`define PERIODIC_TIMER_16BIT_REGS_TOP_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define PTMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("periodic timer check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define PTMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("periodic timer check failed");

`endif

[rtl/core/ptmr_pkg.sv]
// shared types and register codes of the periodic timer
`default_nettype none

package ptmr_pkg;

  typedef enum logic [1:0] {
    KIND_CLK_TICK = 2'd0,
    KIND_UP_TICK  = 2'd1,
    KIND_BUS_RD   = 2'd2,
    KIND_BUS_WR   = 2'd3
  } ptmr_kind_e;

  typedef enum logic [1:0] {
    CSEL_DIV1     = 2'd0,
    CSEL_DIV2     = 2'd1,
    CSEL_UPSTREAM = 2'd2,
    CSEL_RSVD     = 2'd3
  } ptmr_csel_e;

  localparam logic [3:0] OFS_CTRLA    = 4'd0;
  localparam logic [3:0] OFS_CTRLB    = 4'd1;
  localparam logic [3:0] OFS_INTCTRL  = 4'd5;
  localparam logic [3:0] OFS_INTFLAGS = 4'd6;
  localparam logic [3:0] OFS_TEMP     = 4'd9;
  localparam logic [3:0] OFS_CNTL     = 4'd10;
  localparam logic [3:0] OFS_CNTH     = 4'd11;
  localparam logic [3:0] OFS_CCMPL    = 4'd12;
  localparam logic [3:0] OFS_CCMPH    = 4'd13;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
  } ptmr_item_t;

  typedef struct packed {
    logic       valid;
    ptmr_item_t item;
  } ptmr_stage_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } ptmr_result_t;

  typedef struct packed {
    logic capture_flag;
    logic irq_enable;
  } ptmr_status_t;

endpackage

`default_nettype wire

[rtl/core/ptmr_if.sv]
// transfer channels of the periodic timer
`default_nettype none

interface ptmr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] reg_offset;
  logic [7:0] write_data;

  modport source (output valid, output kind, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input kind, input reg_offset, input write_data,
                output ready);
endinterface

interface ptmr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;

  modport source (output valid, output read_data, output irq, input ready);
  modport sink (input valid, input read_data, input irq, output ready);
endinterface

`default_nettype wire

[rtl/core/periodic_timer_16bit_regs_top.sv]
// periodic timer top level with result register
`default_nettype none

`include "periodic_timer_16bit_regs_top_assert.svh"

// Sixteen-bit periodic-interrupt timer behind byte registers. Each input transfer is a
// clock tick, an upstream-timer tick, a bus read or a bus write; each gives exactly one
// result transfer with the read byte (zero unless a read) and the interrupt line. One
// transfer is taken every cycle while results drain; the input register feeds a single
// pass of update logic into the result register, and a stalled result holds in the
// result register while one more item waits in the input register.
module periodic_timer_16bit_regs_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  ptmr_in_if.sink     in_i,
  ptmr_out_if.source  out_o
);
  import ptmr_pkg::*;

  ptmr_stage_t  stage;
  ptmr_result_t result;
  ptmr_status_t status;
  logic         advance;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   out_rd_q;
  logic         out_irq_q;

  assign advance = stage.valid && (!out_valid_q || out_o.ready);

  ptmr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  ptmr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage.item),
    .result_o  (result),
    .status_o  (status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rd_q  <= result.read_data;
      out_irq_q <= result.irq;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_rd_q;
  assign out_o.irq       = out_irq_q;

  `PTMR_ASSERT_NEXT(a_adv_loads_out, advance, out_valid_q)
  `PTMR_ASSERT_NEXT(a_take_fills_in, in_i.valid && in_i.ready, stage.valid)
  `PTMR_ASSERT_NOW(a_irq_tracks_state, out_valid_q,
                   out_irq_q == (status.capture_flag & status.irq_enable))
endmodule

`default_nettype wire

[rtl/core/ptmr_in_reg.sv]
// input register of the periodic timer
`default_nettype none

module ptmr_in_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  ptmr_in_if.sink              in_i,
  input  wire                  advance_i,
  output ptmr_pkg::ptmr_stage_t stage_o
);
  import ptmr_pkg::*;

  logic       valid_q, valid_d;
  ptmr_item_t item_q;
  logic       take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.kind       <= in_i.kind;
      item_q.reg_offset <= in_i.reg_offset;
      item_q.write_data <= in_i.write_data;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;
endmodule

`default_nettype wire

[rtl/core/ptmr_core.sv]
// timer state, counting step and byte register file
`default_nettype none

module ptmr_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    advance_i,
  input  wire ptmr_pkg::ptmr_item_t item_i,
  output ptmr_pkg::ptmr_result_t result_o,
  output ptmr_pkg::ptmr_status_t status_o
);
  import ptmr_pkg::*;

  logic        en_q, en_d;
  logic [1:0]  sel_q, sel_d;
  logic [2:0]  mode_q, mode_d;
  logic        ien_q, ien_d;
  logic        flag_q, flag_d;
  logic [7:0]  temp_q, temp_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cmp_q, cmp_d;
  logic        phase_q, phase_d;

  logic        do_count;
  logic        mode_change;
  logic [7:0]  rd;
  ptmr_kind_e  kind;

  assign kind = ptmr_kind_e'(item_i.kind);

  always_comb begin
    en_d        = en_q;
    sel_d       = sel_q;
    mode_d      = mode_q;
    ien_d       = ien_q;
    flag_d      = flag_q;
    temp_d      = temp_q;
    cnt_d       = cnt_q;
    cmp_d       = cmp_q;
    phase_d     = phase_q;
    do_count    = 1'b0;
    mode_change = 1'b0;
    rd          = 8'd0;

    case (kind)
      KIND_CLK_TICK: begin
        if (en_q && ptmr_csel_e'(sel_q) == CSEL_DIV1) begin
          do_count = 1'b1;
        end else if (en_q && ptmr_csel_e'(sel_q) == CSEL_DIV2) begin
          do_count = phase_q;
          phase_d  = !phase_q;
        end
      end
      KIND_UP_TICK: begin
        do_count = en_q && ptmr_csel_e'(sel_q) == CSEL_UPSTREAM;
      end
      KIND_BUS_RD: begin
        case (item_i.reg_offset)
          OFS_CTRLA:    rd = {5'd0, sel_q, en_q};
          OFS_CTRLB:    rd = {5'd0, mode_q};
          OFS_INTCTRL:  rd = {7'd0, ien_q};
          OFS_INTFLAGS: rd = {7'd0, flag_q};
          OFS_TEMP:     rd = temp_q;
          OFS_CNTL: begin
            rd     = cnt_q[7:0];
            temp_d = cnt_q[15:8];
          end
          OFS_CCMPL: begin
            rd     = cmp_q[7:0];
            temp_d = cmp_q[15:8];
          end
          OFS_CNTH:     rd = temp_q;
          OFS_CCMPH:    rd = temp_q;
          default:      rd = 8'd0;
        endcase
      end
      KIND_BUS_WR: begin
        case (item_i.reg_offset)
          OFS_CTRLA: begin
            en_d        = item_i.write_data[0];
            sel_d       = item_i.write_data[2:1];
            mode_change = (en_q != item_i.write_data[0]) ||
                          (en_q && (sel_q != item_i.write_data[2:1]));
            if (mode_change) begin
              phase_d = 1'b0;
            end
          end
          OFS_CTRLB:    mode_d = item_i.write_data[2:0];
          OFS_INTCTRL:  ien_d  = item_i.write_data[0];
          OFS_INTFLAGS: begin
            if (item_i.write_data[0]) begin
              flag_d = 1'b0;
            end
          end
          OFS_TEMP:     temp_d = item_i.write_data;
          OFS_CNTL:     temp_d = item_i.write_data;
          OFS_CCMPL:    temp_d = item_i.write_data;
          OFS_CNTH:     cnt_d  = {item_i.write_data, temp_q};
          OFS_CCMPH:    cmp_d  = {item_i.write_data, temp_q};
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // counting step: wrap to zero at the compare value
    if (do_count) begin
      if (cnt_q == cmp_q) begin
        cnt_d  = 16'd0;
        flag_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      sel_q   <= 2'd0;
      mode_q  <= 3'd0;
      ien_q   <= 1'b0;
      flag_q  <= 1'b0;
      temp_q  <= 8'd0;
      cnt_q   <= 16'd0;
      cmp_q   <= 16'd0;
      phase_q <= 1'b0;
    end else if (advance_i) begin
      en_q    <= en_d;
      sel_q   <= sel_d;
      mode_q  <= mode_d;
      ien_q   <= ien_d;
      flag_q  <= flag_d;
      temp_q  <= temp_d;
      cnt_q   <= cnt_d;
      cmp_q   <= cmp_d;
      phase_q <= phase_d;
    end
  end

  assign result_o.read_data    = rd;
  assign result_o.irq          = flag_d & ien_d;
  assign status_o.capture_flag = flag_q;
  assign status_o.irq_enable   = ien_q;
endmodule

`default_nettype wire
